FILE: src/serial_packet_link_responder_defines.svh
// Assertion macros used by the checker file.
// Both expect clk and rst_n in scope.
`ifndef SERIAL_PACKET_LINK_RESPONDER_DEFINES_SVH
`define SERIAL_PACKET_LINK_RESPONDER_DEFINES_SVH

// same-cycle implication
`define SLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/slp_pkg.sv
`timescale 1ns / 1ps
package slp_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    typedef logic [7:0] byte_t;

    localparam byte_t PREAMBLE_HI   = 8'h99;
    localparam byte_t PREAMBLE_LO   = 8'h66;
    localparam byte_t BODY_ACK      = 8'h4B;
    localparam byte_t CK_ERR        = 8'hF1;
    localparam byte_t STATUS_MASK   = 8'h80;
    localparam byte_t CMD_ECHO      = 8'h10;
    localparam byte_t DEVICE_ID_RST = 8'h88;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        byte_t             wdata;
    } slp_mem_req_t;

    typedef struct packed {
        byte_t data;
        logic  from_mem;
    } slp_res_t;

endpackage

FILE: src/slp_ram.sv
`timescale 1ns / 1ps
module slp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/slp_ctrl.sv
`timescale 1ns / 1ps
module slp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  slp_pkg::byte_t       byte_in,
    input  logic                 cfg_wr_en,
    input  slp_pkg::byte_t       cfg_wr_data,
    input  slp_pkg::byte_t       mem_rdata,
    output slp_pkg::slp_mem_req_t mem_req,
    output slp_pkg::slp_res_t    res
);
    import slp_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_PRE2, PH_CMD, PH_SKIP1, PH_SKIP2, PH_LEN,
        PH_BODY, PH_CK_HI, PH_CK_LO, PH_DEVID, PH_STATUS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        sending_reg, sending_next;
    byte_t       cmd_reg, cmd_next;
    byte_t       len_reg, len_next;
    logic [15:0] sum_reg, sum_next;
    byte_t       idx_reg, idx_next;
    logic        add_reg, add_next;
    byte_t       dev_id_reg, dev_id_next;

    logic [15:0] sum_cur;
    byte_t       idx_inc;

    // fold the body byte read during the previous beat into the sum
    assign sum_cur = sum_reg + (add_reg ? {8'h00, mem_rdata} : 16'h0000);
    assign idx_inc = idx_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        sending_next = sending_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        sum_next     = sum_cur;
        idx_next     = idx_reg;
        add_next     = 1'b0;
        dev_id_next  = cfg_wr_en ? cfg_wr_data : dev_id_reg;
        mem_req      = '{we: 1'b0, re: 1'b0, addr: idx_reg[ADDR_W-1:0], wdata: byte_in};
        res          = '{data: 8'h00, from_mem: 1'b0};

        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (sending_reg)
                    begin
                        res.data   = PREAMBLE_HI;
                        phase_next = PH_PRE2;
                    end
                    else if (byte_in == PREAMBLE_HI)
                    begin
                        phase_next = PH_PRE2;
                    end
                end
                PH_PRE2:
                begin
                    if (sending_reg)
                    begin
                        res.data   = PREAMBLE_LO;
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        phase_next = (byte_in == PREAMBLE_LO) ? PH_CMD : PH_WAIT;
                    end
                end
                PH_CMD:
                begin
                    if (sending_reg)
                    begin
                        res.data = cmd_reg;
                    end
                    else
                    begin
                        cmd_next = byte_in;
                    end
                    phase_next = PH_SKIP1;
                end
                PH_SKIP1:
                begin
                    phase_next = PH_SKIP2;
                end
                PH_SKIP2:
                begin
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (sending_reg)
                    begin
                        res.data = len_reg;
                    end
                    else
                    begin
                        len_next = byte_in;
                    end
                    phase_next = (len_next != 8'h00) ? PH_BODY : PH_CK_HI;
                    sum_next   = {8'h00, cmd_reg} + {8'h00, len_next};
                    idx_next   = 8'h00;
                end
                PH_BODY:
                begin
                    if (sending_reg)
                    begin
                        // data arrives next cycle; sum catches up then
                        mem_req.re   = 1'b1;
                        res.from_mem = 1'b1;
                        add_next     = 1'b1;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                        res.data   = BODY_ACK;
                        sum_next   = sum_cur + {8'h00, byte_in};
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= len_reg)
                    begin
                        phase_next = PH_CK_HI;
                    end
                end
                PH_CK_HI:
                begin
                    phase_next = PH_CK_LO;
                    if (sending_reg)
                    begin
                        res.data = sum_cur[15:8];
                    end
                    else if (sum_cur[15:8] != byte_in)
                    begin
                        res.data   = CK_ERR;
                        phase_next = PH_WAIT;
                    end
                end
                PH_CK_LO:
                begin
                    phase_next = PH_DEVID;
                    if (sending_reg)
                    begin
                        res.data = sum_cur[7:0];
                    end
                    else if (sum_cur[7:0] != byte_in)
                    begin
                        res.data   = CK_ERR;
                        phase_next = PH_WAIT;
                    end
                end
                PH_DEVID:
                begin
                    res.data   = dev_id_reg;
                    phase_next = PH_STATUS;
                end
                PH_STATUS:
                begin
                    phase_next = PH_WAIT;
                    if (!sending_reg)
                    begin
                        res.data = STATUS_MASK ^ cmd_reg;
                        if (cmd_reg != CMD_ECHO)
                        begin
                            len_next = 8'h00;
                        end
                    end
                    sending_next = !sending_reg;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            sending_reg <= 1'b0;
            cmd_reg     <= 8'h00;
            len_reg     <= 8'h00;
            sum_reg     <= 16'h0000;
            idx_reg     <= 8'h00;
            add_reg     <= 1'b0;
            dev_id_reg  <= DEVICE_ID_RST;
        end
        else
        begin
            phase_reg   <= phase_next;
            sending_reg <= sending_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            idx_reg     <= idx_next;
            add_reg     <= add_next;
            dev_id_reg  <= dev_id_next;
        end
    end

endmodule

FILE: src/serial_packet_link_responder.sv
`timescale 1ns / 1ps
// The answer to a byte is registered and valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the only hold-off is a full result stage
// whose beat is stalled at the output.
// Reply body bytes come from a 256 x 8 payload RAM with a registered read port.
// Reset clears phase, counters and sum and sets the device id to 0x88; the payload RAM is not cleared.
module serial_packet_link_responder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  slp_pkg::byte_t byte_in,
    output logic           out_valid,
    input  logic           out_stall,
    output slp_pkg::byte_t byte_out,
    input  logic           cfg_wr_en,
    input  slp_pkg::byte_t cfg_wr_data
);
    import slp_pkg::*;

    logic         accept;
    slp_mem_req_t mem_req;
    slp_res_t     res;
    byte_t        mem_rdata;

    logic         s1_valid_reg, s1_valid_next;
    byte_t        s1_data_reg;
    logic         s1_mem_reg;

    // hold the input only while the result beat is stuck
    assign in_stall = s1_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    slp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (byte_in),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .mem_rdata  (mem_rdata),
        .mem_req    (mem_req),
        .res        (res)
    );

    slp_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk  (clk),
        .we   (mem_req.we),
        .waddr(mem_req.addr),
        .wdata(mem_req.wdata),
        .re   (mem_req.re),
        .raddr(mem_req.addr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= res.data;
            s1_mem_reg  <= res.from_mem;
        end
    end

    // RAM data stays put until the next accepted beat, so a stalled beat holds
    assign out_valid = s1_valid_reg;
    assign byte_out  = s1_mem_reg ? mem_rdata : s1_data_reg;

endmodule

FILE: src/slp_chk.sv
`timescale 1ns / 1ps
`include "serial_packet_link_responder_defines.svh"
module slp_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input slp_pkg::byte_t byte_out
);

    `SLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(byte_out), "stalled beat changed")
    `SLP_ASSERT_NEXT(a_one_result, in_valid && !in_stall, out_valid, "accepted byte gave no result")
    `SLP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input held without a stuck result")
    `SLP_ASSERT_NEXT(a_no_extra, out_valid && !out_stall && !(in_valid && !in_stall), !out_valid, "result beat without an input")

endmodule

bind serial_packet_link_responder slp_chk u_slp_chk (.*);

FILE: tb/serial_packet_link_responder_tb.sv
`timescale 1ns / 1ps
module serial_packet_link_responder_tb;
    import slp_pkg::*;

    typedef enum logic [3:0] {
        LK_IDLE, LK_SYNC, LK_CMD, LK_PAD1, LK_PAD2, LK_LEN,
        LK_BODY, LK_SUM_HI, LK_SUM_LO, LK_ID, LK_STATUS
    } link_phase_e;

    typedef enum logic [1:0] {
        PKT_GOOD, PKT_BAD_SYNC, PKT_BAD_SUM_HI, PKT_BAD_SUM_LO
    } pkt_fault_e;

    localparam int TOTAL_BEATS = 1050;
    localparam int IDLE_PCT    = 17;

    logic  clk;
    logic  rst_n       = 1'b0;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    byte_t byte_in     = '0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    byte_t byte_out;
    logic  cfg_wr_en   = 1'b0;
    byte_t cfg_wr_data = '0;

    // link state as the responder should hold it
    link_phase_e lk_phase     = LK_IDLE;
    logic        lk_replying  = 1'b0;
    byte_t       lk_cmd       = '0;
    byte_t       lk_len       = '0;
    logic [15:0] lk_sum       = '0;
    byte_t       lk_idx       = '0;
    byte_t       lk_dev_id    = DEVICE_ID_RST;
    byte_t       lk_payload [PAYLOAD_DEPTH];

    byte_t answer_q [$];
    int    beats_sent = 0;
    int    mismatches = 0;
    bit    steady     = 1'b0;

    serial_packet_link_responder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_out    (byte_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic byte_t link_answer(input byte_t b);
        byte_t r;
        byte_t v;
        r = '0;
        case (lk_phase)
            LK_IDLE:
            begin
                if (lk_replying)
                begin
                    r        = PREAMBLE_HI;
                    lk_phase = LK_SYNC;
                end
                else if (b == PREAMBLE_HI)
                    lk_phase = LK_SYNC;
            end
            LK_SYNC:
            begin
                if (lk_replying)
                begin
                    r        = PREAMBLE_LO;
                    lk_phase = LK_CMD;
                end
                else
                    lk_phase = (b == PREAMBLE_LO) ? LK_CMD : LK_IDLE;
            end
            LK_CMD:
            begin
                if (lk_replying)
                    r = lk_cmd;
                else
                    lk_cmd = b;
                lk_phase = LK_PAD1;
            end
            LK_PAD1: lk_phase = LK_PAD2;
            LK_PAD2: lk_phase = LK_LEN;
            LK_LEN:
            begin
                if (lk_replying)
                    r = lk_len;
                else
                    lk_len = b;
                lk_phase = (lk_len != 0) ? LK_BODY : LK_SUM_HI;
                lk_sum   = {8'h00, lk_cmd} + {8'h00, lk_len};
                lk_idx   = '0;
            end
            LK_BODY:
            begin
                if (lk_replying)
                begin
                    v = lk_payload[lk_idx];
                    r = v;
                end
                else
                begin
                    v = b;
                    lk_payload[lk_idx] = b;
                    r = BODY_ACK;
                end
                lk_sum = lk_sum + {8'h00, v};
                lk_idx = lk_idx + 8'd1;
                if (lk_idx >= lk_len)
                    lk_phase = LK_SUM_HI;
            end
            LK_SUM_HI:
            begin
                lk_phase = LK_SUM_LO;
                if (lk_replying)
                    r = lk_sum[15:8];
                else if (lk_sum[15:8] != b)
                begin
                    r        = CK_ERR;
                    lk_phase = LK_IDLE;
                end
            end
            LK_SUM_LO:
            begin
                lk_phase = LK_ID;
                if (lk_replying)
                    r = lk_sum[7:0];
                else if (lk_sum[7:0] != b)
                begin
                    r        = CK_ERR;
                    lk_phase = LK_IDLE;
                end
            end
            LK_ID:
            begin
                r        = lk_dev_id;
                lk_phase = LK_STATUS;
            end
            LK_STATUS:
            begin
                lk_phase = LK_IDLE;
                if (!lk_replying)
                begin
                    r = STATUS_MASK ^ lk_cmd;
                    if (lk_cmd != CMD_ECHO)
                        lk_len = '0;
                end
                lk_replying = !lk_replying;
            end
            default: lk_phase = LK_IDLE;
        endcase
        return r;
    endfunction

    // compare each accepted answer beat, then pick the next stall
    always @(posedge clk)
    begin : answer_check
        byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $error("byte_out: no answer pending, actual %h", byte_out);
                mismatches++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (byte_out !== want)
                begin
                    $error("byte_out: expected %h, actual %h", want, byte_out);
                    mismatches++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_byte(input byte_t b);
        while (!steady && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        answer_q.push_back(link_answer(b));
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (answer_q.size() != 0);
    endtask

    task automatic set_device_id(input byte_t id);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lk_dev_id   = id;
    endtask

    // one request packet and, if it is taken, the reply exchange after it
    task automatic run_exchange(input byte_t cmd, input byte_t len, input pkt_fault_e fault);
        logic [15:0] sum;
        byte_t       d;
        byte_t       flip;
        int          i;
        sum = {8'h00, cmd} + {8'h00, len};
        send_byte(PREAMBLE_HI);
        if (fault == PKT_BAD_SYNC)
        begin
            do
                d = byte_t'($urandom);
            while (d == PREAMBLE_LO);
            send_byte(d);
            return;
        end
        send_byte(PREAMBLE_LO);
        send_byte(cmd);
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom));
        send_byte(len);
        for (i = 0; i < len; i++)
        begin
            d   = byte_t'($urandom);
            sum = sum + {8'h00, d};
            send_byte(d);
        end
        flip = byte_t'($urandom_range(1, 255));
        send_byte((fault == PKT_BAD_SUM_HI) ? (sum[15:8] ^ flip) : sum[15:8]);
        if (fault == PKT_BAD_SUM_HI)
            return;
        send_byte((fault == PKT_BAD_SUM_LO) ? (sum[7:0] ^ flip) : sum[7:0]);
        if (fault == PKT_BAD_SUM_LO)
            return;
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom));
        // master shifts anything while the reply goes out
        while (lk_replying)
            send_byte(byte_t'($urandom));
    endtask

    task automatic send_noise();
        byte_t d;
        repeat ($urandom_range(1, 4))
        begin
            do
                d = byte_t'($urandom);
            while (d == PREAMBLE_HI);
            send_byte(d);
        end
    endtask

    task automatic test_idle_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(PREAMBLE_HI);
        send_byte(8'h00);
        send_byte(PREAMBLE_HI);
        send_byte(PREAMBLE_HI);
    endtask

    task automatic test_empty_echo();
        run_exchange(CMD_ECHO, 8'd0, PKT_GOOD);
    endtask

    task automatic test_checksum_errors();
        run_exchange(8'hFF, 8'd1, PKT_BAD_SUM_HI);
        run_exchange(8'h00, 8'd0, PKT_BAD_SUM_LO);
    endtask

    task automatic test_device_id();
        set_device_id(8'h00);
        run_exchange(8'hFF, 8'd0, PKT_GOOD);
        set_device_id(8'hFF);
        run_exchange(CMD_ECHO, 8'd2, PKT_GOOD);
    endtask

    task automatic test_random_traffic();
        int         iter;
        int         roll;
        byte_t      len;
        byte_t      cmd;
        pkt_fault_e fault;
        iter = 0;
        while (beats_sent < TOTAL_BEATS)
        begin
            steady = (iter >= 10) && (iter < 20);
            if (iter % 25 == 24)
                set_device_id(byte_t'($urandom));
            roll = $urandom_range(99);
            if (iter == 5)
                run_exchange(CMD_ECHO, 8'd255, PKT_GOOD);
            else if (roll < 6)
                send_noise();
            else
            begin
                roll = $urandom_range(99);
                if (roll < 76)
                    fault = PKT_GOOD;
                else if (roll < 84)
                    fault = PKT_BAD_SYNC;
                else if (roll < 92)
                    fault = PKT_BAD_SUM_HI;
                else
                    fault = PKT_BAD_SUM_LO;
                len = ($urandom_range(9) == 0) ? byte_t'($urandom_range(16, 64))
                                               : byte_t'($urandom_range(0, 15));
                cmd = $urandom_range(1) ? CMD_ECHO : byte_t'($urandom);
                run_exchange(cmd, len, fault);
            end
            iter++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_noise();
        test_empty_echo();
        test_checksum_errors();
        test_device_id();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
